// ===== design/mre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mre_pkg
// shared constants and types for the mandelbrot row escape unit
// ----------------------------------------------------------------------------
package mre_pkg;

    localparam int COLUMNS   = 16;
    localparam int COL_W     = 8;
    localparam int CNT_W     = 10;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_TDATA_W = 24;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RE_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RE_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 2'd2;

    localparam logic signed [WORD_W-1:0] RE_START_RST   = 32'shFFFE_6667;
    localparam logic signed [WORD_W-1:0] RE_STEP_RST    = 32'sd4369;
    localparam logic [CNT_W-1:0]         ITER_LIMIT_RST = 10'd64;

    // 4.0 in 16.16
    localparam logic signed [WORD_W-1:0] BAILOUT = 32'sh0004_0000;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;

endpackage

// ===== design/mre_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mre_mul
// shared signed 32x32 multiplier with registered 64-bit product
// ----------------------------------------------------------------------------
module mre_mul (
    input  logic          i_clk,
    input  mre_pkg::t_word i_a,
    input  mre_pkg::t_word i_b,
    output mre_pkg::t_prod o_prod
);

    mre_pkg::t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= mre_pkg::t_prod'(i_a) * mre_pkg::t_prod'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== design/mandelbrot_row_escape_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_row_escape_unit
// escape-time orbit over one row of points in 16.16 fixed point
// ----------------------------------------------------------------------------
//  channel | direction | signals                     | contents
//  s       | in        | i_s_tvalid/o_s_tready/tdata | imag_coord [31:0]
//  m       | out       | o_m_tvalid/i_m_tready/tdata | column [7:0], escape_count [17:8]
//          |           | o_m_tlast                   | last_column
//  cfg     | in        | i_cfg_we/i_cfg_idx/i_cfg_data | re_start, re_step, iter_limit
//
//  one orbit iteration runs on the single shared multiplier in the steps
//  x*x, y*y, x*y, update; a column ends when the limit stops it or on bailout,
//  and its item is then held until i_m_tready takes it
//  a row is one accept then COLUMNS items; o_s_tready is high only between rows
//  synchronous active-low reset clears control state and loads register defaults
// ----------------------------------------------------------------------------
module mandelbrot_row_escape_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // imag_coord [31:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [mre_pkg::OUT_TDATA_W-1:0] o_m_tdata, // column [7:0], escape_count [17:8]
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [mre_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MXX  = 3'd1;
    localparam logic [2:0] S_MYY  = 3'd2;
    localparam logic [2:0] S_MXY  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    logic [2:0] r_state, n_state;

    mre_pkg::t_word r_re_start, r_re_step;
    logic [mre_pkg::CNT_W-1:0] r_iter_limit;

    mre_pkg::t_word r_ci, r_cr, r_zx, r_zy, r_zx2, r_zy2;
    logic [mre_pkg::CNT_W-1:0] r_iter;
    logic [mre_pkg::COL_W-1:0] r_col;

    logic r_out_valid, r_out_last;
    logic [mre_pkg::COL_W-1:0] r_out_col;
    logic [mre_pkg::CNT_W-1:0] r_out_cnt;

    mre_pkg::t_word mul_a, mul_b;
    mre_pkg::t_prod prod;
    mre_pkg::t_word prod_s16, prod_s15, mag_sum;
    logic bail, at_limit, out_take, in_take;

    mre_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // floor shift then keep the low 32 bits
    assign prod_s16 = prod[47:16];
    assign prod_s15 = prod[46:15];
    assign mag_sum  = r_zx2 + prod_s16;
    assign bail     = (mag_sum > mre_pkg::BAILOUT);
    assign at_limit = (r_iter >= r_iter_limit);
    assign out_take = r_out_valid && i_m_tready;
    assign in_take  = i_s_tvalid && o_s_tready;

    always_comb begin
        mul_a = r_zx;
        mul_b = r_zx;
        unique case (r_state)
            S_MYY:   begin mul_a = r_zy; mul_b = r_zy; end
            S_MXY:   begin mul_a = r_zx; mul_b = r_zy; end
            default: begin mul_a = r_zx; mul_b = r_zx; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_take) n_state = S_MXX;
            S_MXX:  n_state = at_limit ? S_WAIT : S_MYY;
            S_MYY:  n_state = S_MXY;
            S_MXY:  n_state = bail ? S_WAIT : S_UPD;
            S_UPD:  n_state = S_MXX;
            S_WAIT: begin
                if (out_take) n_state = r_out_last ? S_IDLE : S_MXX;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_re_start   <= mre_pkg::RE_START_RST;
            r_re_step    <= mre_pkg::RE_STEP_RST;
            r_iter_limit <= mre_pkg::ITER_LIMIT_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mre_pkg::REG_RE_START:   r_re_start   <= i_cfg_data;
                    mre_pkg::REG_RE_STEP:    r_re_step    <= i_cfg_data;
                    mre_pkg::REG_ITER_LIMIT: r_iter_limit <= i_cfg_data[mre_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if ((r_state == S_MXX && at_limit) || (r_state == S_MXY && bail)) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    r_ci   <= i_s_tdata;
                    r_cr   <= r_re_start;
                    r_col  <= '0;
                    r_zx   <= '0;
                    r_zy   <= '0;
                    r_iter <= '0;
                end
            end
            S_MXX: begin
                if (at_limit) begin
                    r_out_col  <= r_col;
                    r_out_cnt  <= r_iter;
                    r_out_last <= (r_col == mre_pkg::LAST_COL);
                end
            end
            S_MYY: r_zx2 <= prod_s16;
            S_MXY: begin
                r_zy2 <= prod_s16;
                if (bail) begin
                    r_out_col  <= r_col;
                    r_out_cnt  <= r_iter;
                    r_out_last <= (r_col == mre_pkg::LAST_COL);
                end
            end
            S_UPD: begin
                r_zy   <= prod_s15 + r_ci;
                r_zx   <= r_zx2 - r_zy2 + r_cr;
                r_iter <= r_iter + 1'b1;
            end
            S_WAIT: begin
                if (out_take && !r_out_last) begin
                    r_col  <= r_col + 1'b1;
                    r_cr   <= r_cr + r_re_step;
                    r_zx   <= '0;
                    r_zy   <= '0;
                    r_iter <= '0;
                end
            end
            default: ;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_cnt, r_out_col};
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_valid_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_state == S_WAIT))
        else $error("result item shown outside the wait state");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("row accepted while a result is pending");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> (r_state == S_IDLE))
        else $error("row did not end after its last item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out_cnt <= r_iter_limit))
        else $error("escape count above the iteration limit");
`endif

endmodule

// ===== tb/sv/tb_mandelbrot_row_escape_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_row_escape_unit
// row requests go in on the slave stream and escape counts are checked as
// they leave the master stream, against an in-bench 16.16 orbit predictor;
// a directed pass over the corner cases is followed by random phases with
// changing view settings, idle patterns and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_mandelbrot_row_escape_unit;

    localparam logic [mre_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RAND_PHASES    = 8;
    localparam int ROWS_PER_PHASE = 26;

    typedef struct packed {
        logic [mre_pkg::COL_W-1:0] column;
        logic [mre_pkg::CNT_W-1:0] escape_count;
        logic                      last_column;
    } t_escape_result;

    class t_escape_scoreboard;
        mre_pkg::t_word            start_re;
        mre_pkg::t_word            step_re;
        logic [mre_pkg::CNT_W-1:0] limit;
        t_escape_result            expected_q[$];
        int                        errors;

        function new();
            start_re = mre_pkg::RE_START_RST;
            step_re  = mre_pkg::RE_STEP_RST;
            limit    = mre_pkg::ITER_LIMIT_RST;
            errors   = 0;
        endfunction

        function void write_reg(logic [mre_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                mre_pkg::REG_RE_START:   start_re = data;
                mre_pkg::REG_RE_STEP:    step_re  = data;
                mre_pkg::REG_ITER_LIMIT: limit    = data[mre_pkg::CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // exact 64-bit product, floor shift, low 32 bits kept
        function mre_pkg::t_word scaled_product(mre_pkg::t_word a, mre_pkg::t_word b, int sh);
            mre_pkg::t_prod pa;
            mre_pkg::t_prod pb;
            mre_pkg::t_prod p;
            pa = a;
            pb = b;
            p  = (pa * pb) >>> sh;
            return p[mre_pkg::WORD_W-1:0];
        endfunction

        function logic [mre_pkg::CNT_W-1:0] escape_iterations(mre_pkg::t_word cr,
                                                              mre_pkg::t_word ci);
            mre_pkg::t_word            zx;
            mre_pkg::t_word            zy;
            mre_pkg::t_word            zx2;
            mre_pkg::t_word            zy2;
            mre_pkg::t_word            mag;
            mre_pkg::t_word            ny;
            logic [mre_pkg::CNT_W-1:0] n;
            zx = '0;
            zy = '0;
            n  = '0;
            while (n < limit) begin
                zx2 = scaled_product(zx, zx, 16);
                zy2 = scaled_product(zy, zy, 16);
                mag = zx2 + zy2;
                // wrapped sum compared as signed
                if (mag > mre_pkg::BAILOUT) break;
                ny = scaled_product(zx, zy, 15) + ci;
                zx = zx2 - zy2 + cr;
                zy = ny;
                n  = n + 1'b1;
            end
            return n;
        endfunction

        function void note_row(mre_pkg::t_word ci);
            t_escape_result r;
            mre_pkg::t_word cr;
            for (int c = 0; c < mre_pkg::COLUMNS; c++) begin
                cr = start_re + step_re * mre_pkg::t_word'(c);
                r.column       = mre_pkg::COL_W'(c);
                r.escape_count = escape_iterations(cr, ci);
                r.last_column  = (c == mre_pkg::COLUMNS - 1);
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(logic [mre_pkg::OUT_TDATA_W-1:0] tdata, logic tlast);
            t_escape_result got;
            t_escape_result want;
            got.column       = tdata[mre_pkg::COL_W-1:0];
            got.escape_count = tdata[mre_pkg::COL_W +: mre_pkg::CNT_W];
            got.last_column  = tlast;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: column %0d count %0d last %0b",
                             got.column, got.escape_count, got.last_column);
                return;
            end
            want = expected_q.pop_front();
            if (want != got) begin
                errors++;
                if (errors <= 10)
                    $display({"result error: column exp %0d got %0d, ",
                              "count exp %0d got %0d, last exp %0b got %0b"},
                             want.column, got.column, want.escape_count, got.escape_count,
                             want.last_column, got.last_column);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                               i_clk      = 1'b0;
    logic                               i_rst_n    = 1'b0;
    logic                               i_s_tvalid = 1'b0;
    logic                               o_s_tready;
    logic [31:0]                        i_s_tdata  = '0;   // imag_coord [31:0]
    logic                               o_m_tvalid;
    logic                               i_m_tready = 1'b0;
    logic [mre_pkg::OUT_TDATA_W-1:0]    o_m_tdata;         // column [7:0], escape_count [17:8]
    logic                               o_m_tlast;
    logic                               i_cfg_we   = 1'b0;
    logic [mre_pkg::CFG_IDX_W-1:0]      i_cfg_idx  = '0;
    logic [31:0]                        i_cfg_data = '0;

    t_escape_scoreboard sb = new();

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    bit hold_req      = 1'b0;
    int quiet_cycles  = 0;

    mandelbrot_row_escape_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // item monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_row(i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tlast);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("mandelbrot_row_escape_unit: mismatch");
                $finish;
            end
        end
    end

    task automatic send_row(mre_pkg::t_word imag);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= imag;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // drop valid and wait until every row has come back
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [mre_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
    endtask

    task automatic set_view(mre_pkg::t_word start_re, mre_pkg::t_word step_re,
                            logic [31:0] limit);
        write_reg(mre_pkg::REG_RE_START, start_re);
        write_reg(mre_pkg::REG_RE_STEP, step_re);
        write_reg(mre_pkg::REG_ITER_LIMIT, limit);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic mre_pkg::t_word pick_imag();
        // mostly inside the interesting band, sometimes anything
        if ($urandom_range(99) < 85)
            return mre_pkg::t_word'($urandom_range(0, 196608)) - 32'sd98304;
        return mre_pkg::t_word'($urandom);
    endfunction

    task automatic run_phase(int mode);
        mre_pkg::t_word start_re;
        mre_pkg::t_word step_re;
        logic [31:0]    limit;
        src_idle_pct   = (mode == 1) ? 48 : (mode == 3) ? 29 : 0;
        sink_stall_pct = (mode == 2) ? 48 : (mode == 3) ? 29 : 0;
        if ($urandom_range(3) == 0)
            start_re = mre_pkg::t_word'($urandom);
        else
            start_re = mre_pkg::t_word'($urandom_range(0, 196608)) - 32'sd163840;
        if ($urandom_range(3) == 0)
            step_re = mre_pkg::t_word'($urandom);
        else
            step_re = mre_pkg::t_word'($urandom_range(0, 16384));
        if ($urandom_range(5) == 0)
            limit = $urandom_range(49, 120);
        else
            limit = $urandom_range(0, 48);
        set_view(start_re, step_re, limit);
        for (int r = 0; r < ROWS_PER_PHASE; r++) send_row(pick_imag());
        settle();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults out of reset
        send_row(32'sh0000_0000);
        send_row(32'sh0001_0000);
        send_row(32'shFFFF_0000);
        send_row(32'sh7FFF_FFFF);
        send_row(32'sh8000_0000);
        send_row(32'shFFFF_FFFF);
        send_row(32'sh0000_0001);
        settle();

        // zero iteration limit, written with junk above the register width,
        // and a write to an unused index that must change nothing
        write_reg(mre_pkg::REG_ITER_LIMIT, 32'hFFFF_FC00);
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        send_row(32'sh0000_0000);
        settle();

        // longest orbits: the zero row lies inside the main cardioid, then a row at imag 4.0
        set_view(32'shFFFF_8000, 32'sh0000_0800, 32'd1023);
        send_row(32'sh0000_0000);
        send_row(32'sh0004_0000);
        settle();

        // coordinate wrap at both ends
        set_view(32'sh7FFF_0000, 32'sh7FFF_FFFF, 32'd20);
        send_row(32'sh7FFF_FFFF);
        send_row(32'sh8000_0000);
        settle();
        set_view(32'sh8000_0000, 32'sh8000_0000, 32'd20);
        send_row(32'sh0000_0000);
        send_row(32'shFFFF_8000);
        settle();

        // ordinary view across the set
        set_view(32'shFFFE_0000, 32'sh0000_3000, 32'd30);
        send_row(32'shFFFF_0000);
        send_row(32'shFFFF_8000);
        send_row(32'sh0000_0000);
        send_row(32'sh0000_8000);
        send_row(32'sh0001_0000);
        settle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 4) hold_req = 1'b1;
            run_phase(p % 4);
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("mandelbrot_row_escape_unit: match");
        else
            $display("mandelbrot_row_escape_unit: mismatch");
        $finish;
    end

endmodule
